FILE: rtl/core/nsg_pkg.sv
`default_nettype none

package nsg_pkg;

    localparam int FREQ_W = 29;
    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    localparam int TABLE_STEPS_DEF = 64;
    localparam int FREQ_FRAC_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SEQ_ENABLE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NOTE_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GLIDE_WEIGHT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OCTAVE_SHIFT = 2'd3;

    localparam logic [15:0] NOTE_LENGTH_RST  = 16'd7938;
    localparam logic [15:0] GLIDE_WEIGHT_RST = 16'd655;

    // Table pitches A3, F3, D3, D4 in Q.24.
    localparam logic [33:0] PITCH_Q24_A3 = 34'd3690987520;
    localparam logic [33:0] PITCH_Q24_F3 = 34'd2929538472;
    localparam logic [33:0] PITCH_Q24_D3 = 34'd2463438891;
    localparam logic [33:0] PITCH_Q24_D4 = 34'd4926877781;

    typedef struct packed {
        logic              seq_enable;
        logic [15:0]       note_length;
        logic [15:0]       glide_weight;
        logic signed [3:0] octave_shift;
    } cfg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] target;
        logic              trigger;
        logic              gate;
    } stage_t;

    typedef struct packed {
        logic [FREQ_W-1:0] out_freq;
        logic              trigger;
        logic              gate;
    } result_t;

    // Rounds a Q.24 pitch to the given number of fraction bits and saturates.
    function automatic logic [FREQ_W-1:0] pitch_fixed(input logic [1:0] sel, input int frac);
        logic [33:0] q;
        logic [34:0] half;
        logic [34:0] r;
        int          s;
        case (sel)
            2'd0:    q = PITCH_Q24_A3;
            2'd1:    q = PITCH_Q24_F3;
            2'd2:    q = PITCH_Q24_D3;
            default: q = PITCH_Q24_D4;
        endcase
        s = 24 - frac;
        half = (s > 0) ? (35'd1 << (s - 1)) : 35'd0;
        r = ({1'b0, q} + half) >> s;
        if (r > {6'd0, FREQ_MAX}) begin
            return FREQ_MAX;
        end
        return r[FREQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/note_sequencer_with_glide.sv
`default_nettype none

// Step sequencer with glide. Each input item is one audio sample tick and
// yields exactly one result item: the glided frequency (Q13.16 Hz by default),
// the step trigger and the gate. The block takes one item per clock cycle unless
// the result side stalls it. In the first register stage it advances the step
// counters and forms the octave-shifted target; the second runs the glide update
// (subtract, 16x29 multiply, add or subtract) whose state feeds back into itself
// on each load. Back-pressure on the result side stalls both stages; the input
// stays ready while either stage has room. Configuration is to be written through
// the cfg port only while no item is in flight; the block does not enforce this.
module note_sequencer_with_glide #(
    parameter int TABLE_STEPS    = nsg_pkg::TABLE_STEPS_DEF,
    parameter int FREQ_FRAC_BITS = nsg_pkg::FREQ_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // [28:0] key_freq

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [31:0]                         m_tdata,   // [28:0] out_freq
    output logic [1:0]                          m_tuser,   // [0] note_trigger, [1] note_gate

    input  wire logic                           cfg_we,
    input  wire logic [nsg_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [nsg_pkg::CFG_DATA_W-1:0] cfg_data
);

    nsg_pkg::cfg_t    cfg_reg;
    logic             s1_valid_reg;
    logic             m_valid_reg;
    logic             m_load;
    logic             s_accept;
    nsg_pkg::stage_t  stage;
    nsg_pkg::result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seq_enable   <= 1'b1;
            cfg_reg.note_length  <= nsg_pkg::NOTE_LENGTH_RST;
            cfg_reg.glide_weight <= nsg_pkg::GLIDE_WEIGHT_RST;
            cfg_reg.octave_shift <= 4'sd0;
        end else if (cfg_we) begin
            case (cfg_index)
                nsg_pkg::REG_SEQ_ENABLE:   cfg_reg.seq_enable   <= cfg_data[0];
                nsg_pkg::REG_NOTE_LENGTH:  cfg_reg.note_length  <= cfg_data;
                nsg_pkg::REG_GLIDE_WEIGHT: cfg_reg.glide_weight <= cfg_data;
                nsg_pkg::REG_OCTAVE_SHIFT: cfg_reg.octave_shift <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign m_load   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || m_load;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    nsg_step #(
        .TABLE_STEPS    (TABLE_STEPS),
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .key_freq (s_tdata[nsg_pkg::FREQ_W-1:0]),
        .cfg      (cfg_reg),
        .stage    (stage)
    );

    nsg_glide u_glide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (m_load),
        .stage        (stage),
        .glide_weight (cfg_reg.glide_weight),
        .result       (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, result.out_freq};
    assign m_tuser  = {result.gate, result.trigger};

`ifndef SYNTHESIS
    // A trigger is only ever issued together with the gate.
    a_trig_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tuser[1])
        else $error("note_trigger without note_gate");

    // A waiting first-stage item moves into the output register when it has room.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (!m_valid_reg || m_tready)) |=> m_tvalid)
        else $error("first-stage item did not advance");

    // With both stages full and the output stalled, no new item is taken.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("item accepted while pipeline full");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/nsg_step.sv
`default_nettype none

module nsg_step #(
    parameter int TABLE_STEPS    = nsg_pkg::TABLE_STEPS_DEF,
    parameter int FREQ_FRAC_BITS = nsg_pkg::FREQ_FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [nsg_pkg::FREQ_W-1:0] key_freq,
    input  wire nsg_pkg::cfg_t              cfg,
    output nsg_pkg::stage_t                 stage
);

    localparam int STEP_W = (TABLE_STEPS > 1) ? $clog2(TABLE_STEPS) : 1;
    // First step of the second, third and fourth quarter of the table.
    localparam int B1 = (TABLE_STEPS + 3) / 4;
    localparam int B2 = (2 * TABLE_STEPS + 3) / 4;
    localparam int B3 = (3 * TABLE_STEPS + 3) / 4;

    localparam logic [nsg_pkg::FREQ_W-1:0] PITCH0 = nsg_pkg::pitch_fixed(2'd0, FREQ_FRAC_BITS);
    localparam logic [nsg_pkg::FREQ_W-1:0] PITCH1 = nsg_pkg::pitch_fixed(2'd1, FREQ_FRAC_BITS);
    localparam logic [nsg_pkg::FREQ_W-1:0] PITCH2 = nsg_pkg::pitch_fixed(2'd2, FREQ_FRAC_BITS);
    localparam logic [nsg_pkg::FREQ_W-1:0] PITCH3 = nsg_pkg::pitch_fixed(2'd3, FREQ_FRAC_BITS);

    logic [STEP_W-1:0]             step_index_reg, step_index_next;
    logic [15:0]                   tick_count_reg, tick_count_next;
    nsg_pkg::stage_t               stage_reg, stage_next;

    logic [15:0]                   len;
    logic [15:0]                   tick_inc;
    logic [nsg_pkg::FREQ_W-1:0]    pitch;
    logic [nsg_pkg::FREQ_W-1:0]    target;
    logic [nsg_pkg::FREQ_W+6:0]    wide;
    logic [3:0]                    rshift;
    logic [nsg_pkg::FREQ_W-1:0]    shifted;

    always_comb begin
        len = (cfg.note_length == 16'd0) ? 16'd1 : cfg.note_length;
        tick_inc = tick_count_reg + 16'd1;
        tick_count_next = tick_inc;
        step_index_next = step_index_reg;
        if (tick_inc == 16'd0 || tick_inc >= len) begin
            tick_count_next = 16'd0;
            if (step_index_reg == STEP_W'(TABLE_STEPS - 1)) begin
                step_index_next = '0;
            end else begin
                step_index_next = step_index_reg + STEP_W'(1);
            end
        end
    end

    always_comb begin
        if ({1'b0, step_index_reg} >= (STEP_W + 1)'(B3)) begin
            pitch = PITCH3;
        end else if ({1'b0, step_index_reg} >= (STEP_W + 1)'(B2)) begin
            pitch = PITCH2;
        end else if ({1'b0, step_index_reg} >= (STEP_W + 1)'(B1)) begin
            pitch = PITCH1;
        end else begin
            pitch = PITCH0;
        end
        target = cfg.seq_enable ? pitch : key_freq;

        // Left shifts saturate; right shifts truncate.
        wide = {7'd0, target} << cfg.octave_shift[2:0];
        rshift = ~cfg.octave_shift + 4'd1;
        if (!cfg.octave_shift[3]) begin
            shifted = (|wide[nsg_pkg::FREQ_W+6:nsg_pkg::FREQ_W]) ? nsg_pkg::FREQ_MAX
                                                                 : wide[nsg_pkg::FREQ_W-1:0];
        end else begin
            shifted = target >> rshift;
        end

        stage_next.target = shifted;
        stage_next.trigger = cfg.seq_enable && (tick_count_reg == 16'd0);
        stage_next.gate = cfg.seq_enable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_index_reg <= '0;
            tick_count_reg <= 16'd0;
        end else if (load) begin
            step_index_reg <= step_index_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nsg_glide.sv
`default_nettype none

module nsg_glide (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire nsg_pkg::stage_t stage,
    input  wire logic [15:0]     glide_weight,
    output nsg_pkg::result_t     result
);

    logic [nsg_pkg::FREQ_W-1:0]  glide_freq_reg, glide_freq_next;
    nsg_pkg::result_t            result_reg, result_next;

    logic                        rising;
    logic [nsg_pkg::FREQ_W-1:0]  diff;
    logic [nsg_pkg::FREQ_W+15:0] prod;
    logic [nsg_pkg::FREQ_W-1:0]  delta;
    logic [nsg_pkg::FREQ_W:0]    sum;

    always_comb begin
        rising = stage.target >= glide_freq_reg;
        diff = rising ? (stage.target - glide_freq_reg) : (glide_freq_reg - stage.target);
        prod = {{nsg_pkg::FREQ_W{1'b0}}, glide_weight} * {16'd0, diff};
        delta = prod[nsg_pkg::FREQ_W+15:16];
        sum = {1'b0, glide_freq_reg} + {1'b0, delta};
        if (rising) begin
            glide_freq_next = sum[nsg_pkg::FREQ_W] ? nsg_pkg::FREQ_MAX
                                                   : sum[nsg_pkg::FREQ_W-1:0];
        end else begin
            glide_freq_next = glide_freq_reg - delta;
        end
        result_next.out_freq = glide_freq_next;
        result_next.trigger = stage.trigger;
        result_next.gate = stage.gate;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glide_freq_reg <= '0;
        end else if (load) begin
            glide_freq_reg <= glide_freq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
